// File: sv/cvcp_pkg.sv
// Shared types and constants for the cell voltage to charge percent converter.
// Holds the discharge curve tables and the stage payload structs; no dependencies.
package cvcp_pkg;

  localparam int CURVE_POINTS = 10;
  localparam int MV_W         = 16;
  localparam int PCT_W        = 7;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int DIST_W       = 8;
  localparam int NUM_W        = 11;
  localparam int RECIP_W      = 11;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_W       = NUM_W + RECIP_W;
  localparam int Q_W          = PROD_W - RECIP_SHIFT;
  localparam int SPAN_PCT_W   = 4;

  localparam logic [PCT_W-1:0] PCT_MIN = PCT_W'(0);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Curve points, strictly rising in voltage.
  localparam logic [MV_W-1:0] PT_MV [CURVE_POINTS] = '{
    16'd3300, 16'd3500, 16'd3600, 16'd3700, 16'd3750,
    16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4200
  };
  localparam logic [PCT_W-1:0] PT_PCT [CURVE_POINTS] = '{
    7'd0, 7'd5, 7'd10, 7'd25, 7'd40, 7'd55, 7'd70, 7'd85, 7'd95, 7'd100
  };

  // Per segment, indexed by the closing point; entry 0 has no segment.
  localparam logic [DIST_W-1:0] SPAN_MV [CURVE_POINTS] = '{
    8'd0, 8'd200, 8'd100, 8'd100, 8'd50, 8'd50, 8'd100, 8'd100, 8'd100, 8'd100
  };
  localparam logic [SPAN_PCT_W-1:0] SPAN_PCT [CURVE_POINTS] = '{
    4'd0, 4'd5, 4'd5, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd5
  };
  // floor(2^16 / span); the quotient estimate it gives is at most one low.
  localparam logic [RECIP_W-1:0] RECIP [CURVE_POINTS] = '{
    11'd0, 11'd327, 11'd655, 11'd655, 11'd1310, 11'd1310,
    11'd655, 11'd655, 11'd655, 11'd655
  };

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [SEG_W-1:0] seg;
    logic [MV_W-1:0]  mv;
  } cvcp_seg_t;

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [SEG_W-1:0] seg;
    logic [NUM_W-1:0] num;
  } cvcp_num_t;

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [SEG_W-1:0] seg;
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   q;
  } cvcp_quot_t;

endpackage

// File: sv/cell_voltage_to_charge_percent.sv
// Converts a cell voltage in millivolts to a charge percentage along a fixed
// ten-point lithium discharge curve, interpolating within the segment and rounding
// to nearest; inputs at or below 3300 mV give 0 and at or above 4200 mV give 100.
// The pipeline has four register stages (segment search, scaling, reciprocal
// multiply, correction and output); one voltage can be taken every cycle unless
// out_stall has backed the pipeline up to the input. Each stage holds its own
// valid bit, so out_stall only backs up stages that are full.
// Depends on cvcp_pkg, cvcp_seg, cvcp_scale and cvcp_divide.
module cell_voltage_to_charge_percent (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cvcp_pkg::MV_W-1:0]  in_cell_millivolts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cvcp_pkg::PCT_W-1:0] out_charge_percent
);

  logic                seg_valid;
  logic                seg_stall;
  cvcp_pkg::cvcp_seg_t seg_data;
  logic                num_valid;
  logic                num_stall;
  cvcp_pkg::cvcp_num_t num_data;

  cvcp_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_mv    (in_cell_millivolts),
    .up_stall (in_stall),
    .dn_valid (seg_valid),
    .dn_data  (seg_data),
    .dn_stall (seg_stall)
  );

  cvcp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (seg_valid),
    .up_data  (seg_data),
    .up_stall (seg_stall),
    .dn_valid (num_valid),
    .dn_data  (num_data),
    .dn_stall (num_stall)
  );

  cvcp_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (num_valid),
    .up_data  (num_data),
    .up_stall (num_stall),
    .dn_valid (out_valid),
    .dn_pct   (out_charge_percent),
    .dn_stall (out_stall)
  );

endmodule

// File: sv/cvcp_seg.sv
// Stage 1: compares the voltage against every curve point and picks the segment.
// Depends on cvcp_pkg.
module cvcp_seg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  input  logic [cvcp_pkg::MV_W-1:0] up_mv,
  output logic                      up_stall,
  output logic                      dn_valid,
  output cvcp_pkg::cvcp_seg_t       dn_data,
  input  logic                      dn_stall
);

  logic                valid_r;
  cvcp_pkg::cvcp_seg_t data_r;
  cvcp_pkg::cvcp_seg_t data_nxt;
  logic                advance;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    logic [cvcp_pkg::SEG_W-1:0] seg;
    seg = cvcp_pkg::SEG_W'(1);
    // The first point at or above the input closes the segment.
    for (int k = cvcp_pkg::CURVE_POINTS - 1; k >= 1; k--) begin
      if (up_mv <= cvcp_pkg::PT_MV[k]) begin
        seg = cvcp_pkg::SEG_W'(k);
      end
    end
    data_nxt.sat_lo = (up_mv <= cvcp_pkg::PT_MV[0]);
    data_nxt.sat_hi = (up_mv >= cvcp_pkg::PT_MV[cvcp_pkg::CURVE_POINTS - 1]);
    data_nxt.seg    = seg;
    data_nxt.mv     = up_mv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/cvcp_scale.sv
// Stage 2: distance into the segment, scaled by the segment's percent span plus
// the rounding half span. Depends on cvcp_pkg.
module cvcp_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  cvcp_pkg::cvcp_seg_t up_data,
  output logic                up_stall,
  output logic                dn_valid,
  output cvcp_pkg::cvcp_num_t dn_data,
  input  logic                dn_stall
);

  logic                valid_r;
  cvcp_pkg::cvcp_num_t data_r;
  cvcp_pkg::cvcp_num_t data_nxt;
  logic                advance;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    logic [cvcp_pkg::SEG_W-1:0]  lo;
    logic [cvcp_pkg::MV_W-1:0]   diff;
    logic [cvcp_pkg::DIST_W-1:0] delta;
    lo    = cvcp_pkg::SEG_W'(up_data.seg - cvcp_pkg::SEG_W'(1));
    diff  = up_data.mv - cvcp_pkg::PT_MV[lo];
    // Inside a segment the distance never exceeds the segment's span.
    delta = diff[cvcp_pkg::DIST_W-1:0];
    data_nxt.sat_lo = up_data.sat_lo;
    data_nxt.sat_hi = up_data.sat_hi;
    data_nxt.seg    = up_data.seg;
    data_nxt.num    = cvcp_pkg::NUM_W'(delta)
                        * cvcp_pkg::NUM_W'(cvcp_pkg::SPAN_PCT[up_data.seg])
                    + cvcp_pkg::NUM_W'(cvcp_pkg::SPAN_MV[up_data.seg] >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/cvcp_divide.sv
// Stages 3 and 4: division by the segment span through a reciprocal multiply,
// a one-step correction, and the final percent in the output register.
// Depends on cvcp_pkg.
module cvcp_divide (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  cvcp_pkg::cvcp_num_t        up_data,
  output logic                       up_stall,
  output logic                       dn_valid,
  output logic [cvcp_pkg::PCT_W-1:0] dn_pct,
  input  logic                       dn_stall
);

  logic                       q_valid_r;
  cvcp_pkg::cvcp_quot_t       q_data_r;
  cvcp_pkg::cvcp_quot_t       q_data_nxt;
  logic                       out_valid_r;
  logic [cvcp_pkg::PCT_W-1:0] pct_r;
  logic [cvcp_pkg::PCT_W-1:0] pct_nxt;
  logic                       out_advance;
  logic                       q_advance;

  assign out_advance = !out_valid_r || !dn_stall;
  assign q_advance   = !q_valid_r || out_advance;
  assign up_stall    = !q_advance;
  assign dn_valid    = out_valid_r;
  assign dn_pct      = pct_r;

  always_comb begin
    logic [cvcp_pkg::PROD_W-1:0] prod;
    prod = cvcp_pkg::PROD_W'(up_data.num) * cvcp_pkg::PROD_W'(cvcp_pkg::RECIP[up_data.seg]);
    q_data_nxt.sat_lo = up_data.sat_lo;
    q_data_nxt.sat_hi = up_data.sat_hi;
    q_data_nxt.seg    = up_data.seg;
    q_data_nxt.num    = up_data.num;
    q_data_nxt.q      = prod[cvcp_pkg::PROD_W-1:cvcp_pkg::RECIP_SHIFT];
  end

  always_comb begin
    logic [cvcp_pkg::SEG_W-1:0]  lo;
    logic [cvcp_pkg::DIST_W-1:0] span;
    logic [cvcp_pkg::NUM_W-1:0]  qspan;
    logic [cvcp_pkg::NUM_W-1:0]  rem;
    logic [cvcp_pkg::Q_W-1:0]    step;
    lo    = cvcp_pkg::SEG_W'(q_data_r.seg - cvcp_pkg::SEG_W'(1));
    span  = cvcp_pkg::SPAN_MV[q_data_r.seg];
    qspan = cvcp_pkg::NUM_W'(q_data_r.q) * cvcp_pkg::NUM_W'(span);
    rem   = q_data_r.num - qspan;
    // The estimate is low by at most one; a zero-width segment adds nothing.
    if (span == '0) begin
      step = '0;
    end else if (rem >= cvcp_pkg::NUM_W'(span)) begin
      step = cvcp_pkg::Q_W'(q_data_r.q + cvcp_pkg::Q_W'(1));
    end else begin
      step = q_data_r.q;
    end
    priority if (q_data_r.sat_lo) begin
      pct_nxt = cvcp_pkg::PCT_MIN;
    end else if (q_data_r.sat_hi) begin
      pct_nxt = cvcp_pkg::PCT_MAX;
    end else begin
      pct_nxt = cvcp_pkg::PCT_W'(cvcp_pkg::PT_PCT[lo] + cvcp_pkg::PCT_W'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_advance) begin
        q_valid_r <= up_valid;
      end
      if (out_advance) begin
        out_valid_r <= q_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_advance && up_valid) begin
      q_data_r <= q_data_nxt;
    end
    if (out_advance && q_valid_r) begin
      pct_r <= pct_nxt;
    end
  end

endmodule

// File: tb/tb_cell_voltage_to_charge_percent.sv
`timescale 1ns / 100ps
// Self-checking testbench for cell_voltage_to_charge_percent, a discharge-curve lookup.
// It drives directed and random voltages through the valid/stall handshake and checks
// each percentage against a local curve predictor. Depends on cvcp_pkg and the block.
module tb_cell_voltage_to_charge_percent;

  localparam int NUM_KNOTS        = 10;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int DRAIN_CYCLES     = 16;
  localparam int IDLE_LIMIT       = 4000;
  localparam int NUM_ROWS         = 23;

  // The discharge curve, kept here so that a wrong table in the design is caught.
  localparam int unsigned KNOT_MV [NUM_KNOTS] = '{
    3300, 3500, 3600, 3700, 3750, 3800, 3900, 4000, 4100, 4200
  };
  localparam int unsigned KNOT_PCT [NUM_KNOTS] = '{
    0, 5, 10, 25, 40, 55, 70, 85, 95, 100
  };

  typedef struct {
    logic [cvcp_pkg::MV_W-1:0]  mv;
    logic [cvcp_pkg::PCT_W-1:0] pct;
  } pct_expect_t;

  typedef struct {
    logic [cvcp_pkg::MV_W-1:0]  mv;
    bit                         known;
    logic [cvcp_pkg::PCT_W-1:0] pct;
  } voltage_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [cvcp_pkg::MV_W-1:0]  in_cell_millivolts = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [cvcp_pkg::PCT_W-1:0] out_charge_percent;

  pct_expect_t pending_percent_q [$];
  pct_expect_t head_expect;
  int          err_count = 0;
  int          voltages_sent = 0;
  int          percents_checked = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // Rows with a known percentage are extremes or curve points; the rest use the predictor.
  voltage_row_t voltage_rows [NUM_ROWS] = '{
    '{16'd0,     1'b1, 7'd0},
    '{16'd65535, 1'b1, 7'd100},
    '{16'd3300,  1'b1, 7'd0},
    '{16'd4200,  1'b1, 7'd100},
    '{16'd3299,  1'b1, 7'd0},
    '{16'd4201,  1'b1, 7'd100},
    '{16'd3500,  1'b1, 7'd5},
    '{16'd3600,  1'b1, 7'd10},
    '{16'd3700,  1'b1, 7'd25},
    '{16'd3750,  1'b1, 7'd40},
    '{16'd3800,  1'b1, 7'd55},
    '{16'd3900,  1'b1, 7'd70},
    '{16'd4000,  1'b1, 7'd85},
    '{16'd4100,  1'b1, 7'd95},
    '{16'd32768, 1'b1, 7'd100},
    '{16'd255,   1'b1, 7'd0},
    '{16'd3301,  1'b0, 7'd0},
    '{16'd4199,  1'b0, 7'd0},
    '{16'd3520,  1'b0, 7'd0},
    '{16'd3510,  1'b0, 7'd0},
    '{16'd3725,  1'b0, 7'd0},
    '{16'd3650,  1'b0, 7'd0},
    '{16'd3333,  1'b0, 7'd0}
  };

  cell_voltage_to_charge_percent uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_millivolts (in_cell_millivolts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_percent (out_charge_percent)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Interpolates inside the segment closed by the first knot at or above the voltage,
  // rounding to nearest with ties going up.
  function automatic logic [cvcp_pkg::PCT_W-1:0] charge_from_millivolts(
    input logic [cvcp_pkg::MV_W-1:0] mv
  );
    int unsigned span_mv;
    int unsigned span_pct;
    int unsigned offset_mv;
    int unsigned step;
    if (mv <= KNOT_MV[0]) return cvcp_pkg::PCT_MIN;
    if (mv >= KNOT_MV[NUM_KNOTS-1]) return cvcp_pkg::PCT_MAX;
    for (int k = 1; k < NUM_KNOTS; k++) begin
      if (mv <= KNOT_MV[k]) begin
        span_mv   = KNOT_MV[k] - KNOT_MV[k-1];
        span_pct  = KNOT_PCT[k] - KNOT_PCT[k-1];
        offset_mv = mv - KNOT_MV[k-1];
        step      = 0;
        if (span_mv != 0) step = (offset_mv * span_pct + span_mv / 2) / span_mv;
        return cvcp_pkg::PCT_W'(KNOT_PCT[k-1] + step);
      end
    end
    return cvcp_pkg::PCT_MAX;
  endfunction

  task automatic report_mismatch(input string what, input logic [cvcp_pkg::MV_W-1:0] mv,
                                 input logic [cvcp_pkg::PCT_W-1:0] got,
                                 input logic [cvcp_pkg::PCT_W-1:0] want);
    $display("%0t ns: mismatch, %s: mv=%0d got=%0d want=%0d", $time, what, mv, got, want);
    err_count++;
  endtask

  // Presents one voltage and holds it until the transfer; starts and ends on a rising edge.
  task automatic send_voltage(input logic [cvcp_pkg::MV_W-1:0] mv, input bit known,
                              input logic [cvcp_pkg::PCT_W-1:0] known_pct);
    pct_expect_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cell_millivolts <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e.mv  = mv;
    e.pct = known ? known_pct : charge_from_millivolts(mv);
    pending_percent_q.push_back(e);
    voltages_sent++;
  endtask

  // Most random voltages fall on the curve, a share sit right around knots, the rest
  // spread over the whole 16-bit range so every input bit toggles.
  function automatic logic [cvcp_pkg::MV_W-1:0] random_voltage();
    int sel;
    int knot;
    sel = $urandom_range(99);
    if (sel < 55) return cvcp_pkg::MV_W'($urandom_range(4210, 3290));
    if (sel < 75) begin
      knot = $urandom_range(NUM_KNOTS - 1);
      return cvcp_pkg::MV_W'(KNOT_MV[knot] + $urandom_range(8) - 4);
    end
    return cvcp_pkg::MV_W'($urandom);
  endfunction

  task automatic send_random_phase(input int n);
    for (int i = 0; i < n; i++) send_voltage(random_voltage(), 1'b0, cvcp_pkg::PCT_MIN);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_percent_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_charge_percent, '0);
      end else begin
        head_expect = pending_percent_q.pop_front();
        percents_checked++;
        if (out_charge_percent !== head_expect.pct)
          report_mismatch("charge_percent", head_expect.mv, out_charge_percent,
                          head_expect.pct);
      end
    end
  end

  // Ends the run when neither channel has made a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results pending", $time,
                 IDLE_LIMIT, pending_percent_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    stall_pct     = 66;
    foreach (voltage_rows[r])
      send_voltage(voltage_rows[r].mv, voltage_rows[r].known, voltage_rows[r].pct);
    send_random_phase(RANDOM_PER_PHASE);

    send_idle_pct = 66;
    stall_pct     = 31;
    send_random_phase(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    stall_pct     = 0;
    send_random_phase(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    while (pending_percent_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d voltages (%0d directed) and checked %0d percentages,",
             voltages_sent, NUM_ROWS, percents_checked);
    $display("under sender gaps, receiver stalls and back-to-back traffic; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
